/* rtl/core/vcu_pkg.sv */
// Package for the vector clock unit: payload widths, codes, cell control.
// No dependencies; imported by vcu_cell, vector_clock_unit, the monitor and the testbench.
`default_nettype none

package vcu_pkg;

    localparam int LANES    = 8;
    localparam int CNT_W    = 32;
    localparam int CFG_W    = 4;
    localparam int IDX_W    = 4;
    localparam int S_DATA_W = 264;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 264;

    localparam logic REG_DIMENSION = 1'b0;
    localparam logic REG_OWN_INDEX = 1'b1;

    typedef enum logic [1:0] {
        KIND_LOCAL          = 2'd0,
        KIND_RECV           = 2'd1,
        KIND_STORED_BEFORE  = 2'd2,
        KIND_GIVEN_BEFORE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_DIM_MISMATCH = 2'd1,
        ST_SAME_SENDER  = 2'd2,
        ST_BAD_CONFIG   = 2'd3
    } t_status;

    typedef struct packed {
        logic upd;
        logic active;
        logic merge;
        logic incr;
    } t_cell_ctl;

endpackage

`default_nettype wire

/* rtl/core/vcu_cell.sv */
// One lane of the vector clock: a 32-bit counter with max-merge and increment.
// Passes the running greater/less flags to its neighbor. Uses vcu_pkg.
`default_nettype none

module vcu_cell
    import vcu_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cell_ctl        i_ctl,
    input  wire logic [CNT_W-1:0] i_given,
    input  wire logic             i_gt,
    input  wire logic             i_lt,
    output logic                  o_gt,
    output logic                  o_lt,
    output logic [CNT_W-1:0]      o_count_next
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] merged;
    logic             stored_gt;
    logic             stored_lt;

    assign stored_gt = r_count > i_given;
    assign stored_lt = r_count < i_given;

    assign o_gt = i_gt | (i_ctl.active & stored_gt);
    assign o_lt = i_lt | (i_ctl.active & stored_lt);

    always_comb begin
        merged = (i_ctl.merge && stored_lt) ? i_given : r_count;
        n_count = r_count;
        if (i_ctl.upd) begin
            n_count = i_ctl.incr ? merged + CNT_W'(1) : merged;
        end
    end

    assign o_count_next = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/vector_clock_unit.sv */
// Top level of the vector clock unit: configuration, row of lane cells, output register.
// Depends on vcu_pkg and vcu_cell.
//
// One word is taken every clock cycle: a local event, a merge of a received
// vector or a happens-before compare all finish in the cycle they are accepted,
// since every lane cell updates its own counter in parallel and the compare
// flags ripple once along the row of cells. The result, with all eight counters
// after the step, is held in an output register; the input stays ready while
// that register is empty or being drained. Lanes at or above MAX_PROCESSES
// have no cell and always report zero.
`default_nettype none

module vector_clock_unit
    import vcu_pkg::*;
#(
    parameter int MAX_PROCESSES = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_idx,
    input  wire logic [CFG_W-1:0]    i_cfg_data,
    input  wire logic                i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // other_index, other_dimension, elem0..elem7
    input  wire logic [S_DATA_W-1:0] i_s_axis_tdata,
    // kind
    input  wire logic [S_USER_W-1:0] i_s_axis_tuser,
    output logic                     o_m_axis_tvalid,
    input  wire logic                i_m_axis_tready,
    // status, before_flag, clock0..clock7, zero pad
    output logic [M_DATA_W-1:0]      o_m_axis_tdata
);

    localparam logic [IDX_W-1:0] MaxProc = IDX_W'(MAX_PROCESSES);

    logic [CFG_W-1:0]    r_dimension;
    logic [CFG_W-1:0]    r_own_index;
    logic                r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;
    logic [M_DATA_W-1:0] n_out_data;

    logic [IDX_W-1:0]    other_index;
    logic [IDX_W-1:0]    other_dim;
    t_kind               kind;
    logic                accept;
    logic                bad_cfg;
    logic                do_upd;
    logic                do_merge;
    t_status             status;
    logic                before_flag;

    logic [CNT_W-1:0]    given   [LANES];
    logic [CNT_W-1:0]    cnt_nxt [LANES];
    logic [MAX_PROCESSES:0] gt_chain;
    logic [MAX_PROCESSES:0] lt_chain;

    assign other_index = i_s_axis_tdata[IDX_W-1:0];
    assign other_dim   = i_s_axis_tdata[2*IDX_W-1:IDX_W];
    assign kind        = t_kind'(i_s_axis_tuser);

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    assign bad_cfg = (r_dimension == '0) || (r_dimension > MaxProc) ||
                     (r_own_index == '0) || (r_own_index > r_dimension);

    always_comb begin
        status      = ST_OK;
        do_upd      = 1'b0;
        do_merge    = 1'b0;
        before_flag = 1'b0;
        if (bad_cfg) begin
            status = ST_BAD_CONFIG;
        end else if (kind == KIND_LOCAL) begin
            do_upd = 1'b1;
        end else if (other_dim != r_dimension) begin
            status = ST_DIM_MISMATCH;
        end else begin
            case (kind)
                KIND_RECV: begin
                    if (other_index == r_own_index) begin
                        status = ST_SAME_SENDER;
                    end else begin
                        do_upd   = 1'b1;
                        do_merge = 1'b1;
                    end
                end
                KIND_STORED_BEFORE: begin
                    before_flag = !gt_chain[MAX_PROCESSES] && lt_chain[MAX_PROCESSES];
                end
                KIND_GIVEN_BEFORE: begin
                    before_flag = !lt_chain[MAX_PROCESSES] && gt_chain[MAX_PROCESSES];
                end
                default: begin
                    before_flag = 1'b0;
                end
            endcase
        end
    end

    assign gt_chain[0] = 1'b0;
    assign lt_chain[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < LANES; g++) begin : g_lane
            assign given[g] = i_s_axis_tdata[2*IDX_W + g*CNT_W +: CNT_W];
            if (g < MAX_PROCESSES) begin : g_cell
                t_cell_ctl ctl;
                assign ctl.upd    = accept && do_upd;
                assign ctl.active = IDX_W'(g) < r_dimension;
                assign ctl.merge  = do_merge && (IDX_W'(g) < r_dimension);
                assign ctl.incr   = IDX_W'(g + 1) == r_own_index;

                vcu_cell u_cell (
                    .i_clk        (i_clk),
                    .i_rst_n      (i_rst_n),
                    .i_ctl        (ctl),
                    .i_given      (given[g]),
                    .i_gt         (gt_chain[g]),
                    .i_lt         (lt_chain[g]),
                    .o_gt         (gt_chain[g+1]),
                    .o_lt         (lt_chain[g+1]),
                    .o_count_next (cnt_nxt[g])
                );
            end else begin : g_none
                assign cnt_nxt[g] = '0;
            end
        end
    endgenerate

    always_comb begin
        n_out_data      = '0;
        n_out_data[1:0] = status;
        n_out_data[2]   = before_flag;
        for (int k = 0; k < LANES; k++) begin
            n_out_data[3 + k*CNT_W +: CNT_W] = cnt_nxt[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dimension <= CFG_W'(8);
            r_own_index <= CFG_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_DIMENSION) begin
                r_dimension <= i_cfg_data;
            end else begin
                r_own_index <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

/* tb/sv/vector_clock_unit_monitor.sv */
// Scoreboard for the vector clock unit: watches config, input and output words,
// predicts each result from its own copy of the clock and compares field by field.
// Depends on vcu_pkg.
module vector_clock_unit_monitor
    import vcu_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_idx,
    input  wire logic [CFG_W-1:0]    i_cfg_data,
    input  wire logic                i_s_tvalid,
    input  wire logic                i_s_tready,
    // other_index, other_dimension, elem0..elem7
    input  wire logic [S_DATA_W-1:0] i_s_tdata,
    // kind
    input  wire logic [S_USER_W-1:0] i_s_tuser,
    input  wire logic                i_m_tvalid,
    input  wire logic                i_m_tready,
    // status, before_flag, clock0..clock7, zero pad
    input  wire logic [M_DATA_W-1:0] i_m_tdata,
    output int                       o_errors,
    output int                       o_pending,
    output int                       o_checked,
    output int                       o_held
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PROCS      = 8;
    localparam int REPORT_MAX = 40;
    localparam int VEC_W      = LANES * CNT_W;

    typedef logic [LANES-1:0][CNT_W-1:0] t_lanes;

    typedef struct packed {
        t_status status;
        logic    before_flag;
        t_lanes  clocks;
    } t_clock_result;

    t_lanes          counts;
    logic [CFG_W-1:0] cfg_dim;
    logic [CFG_W-1:0] cfg_own;
    t_clock_result   results_due[$];
    t_clock_result   want;
    t_clock_result   got;

    function automatic logic happens_before(t_lanes a, t_lanes b, int unsigned n);
        logic some_less;
        some_less = 1'b0;
        for (int unsigned i = 0; i < n; i++) begin
            if (a[i] > b[i]) return 1'b0;
            if (a[i] < b[i]) some_less = 1'b1;
        end
        return some_less;
    endfunction

    function automatic t_clock_result step_clock(t_kind kind, logic [IDX_W-1:0] other_idx,
                                                 logic [CFG_W-1:0] other_dim, t_lanes given);
        t_clock_result r;
        r.status = ST_OK;
        r.before_flag = 1'b0;
        if (cfg_dim == 0 || cfg_dim > PROCS || cfg_own == 0 || cfg_own > cfg_dim) begin
            r.status = ST_BAD_CONFIG;
        end else if (kind == KIND_LOCAL) begin
            counts[cfg_own - 1] = counts[cfg_own - 1] + CNT_W'(1);
        end else if (other_dim != cfg_dim) begin
            r.status = ST_DIM_MISMATCH;
        end else if (kind == KIND_RECV) begin
            if (other_idx == cfg_own) begin
                r.status = ST_SAME_SENDER;
            end else begin
                for (int unsigned i = 0; i < cfg_dim; i++)
                    if (given[i] > counts[i]) counts[i] = given[i];
                counts[cfg_own - 1] = counts[cfg_own - 1] + CNT_W'(1);
            end
        end else if (kind == KIND_STORED_BEFORE) begin
            r.before_flag = happens_before(counts, given, 32'(cfg_dim));
        end else begin
            r.before_flag = happens_before(given, counts, 32'(cfg_dim));
        end
        r.clocks = counts;
        return r;
    endfunction

    task automatic flag_mismatch(string what, logic [CNT_W-1:0] seen, logic [CNT_W-1:0] exp);
        if (o_errors < REPORT_MAX)
            $display("[%0t] mismatch on %s: got %0h, want %0h (result %0d)",
                     $realtime, what, seen, exp, o_checked);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            counts = '0;
            cfg_dim = 4'd8;
            cfg_own = 4'd1;
            results_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (results_due.size() == 0) begin
                    flag_mismatch("unexpected result", i_m_tdata[CNT_W-1:0], '0);
                end else begin
                    want = results_due.pop_front();
                    got.status = t_status'(i_m_tdata[1:0]);
                    got.before_flag = i_m_tdata[2];
                    got.clocks = i_m_tdata[VEC_W+2:3];
                    if (got.status !== want.status)
                        flag_mismatch("status", CNT_W'(got.status), CNT_W'(want.status));
                    if (got.before_flag !== want.before_flag)
                        flag_mismatch("before_flag", CNT_W'(got.before_flag),
                                      CNT_W'(want.before_flag));
                    for (int i = 0; i < LANES; i++)
                        if (got.clocks[i] !== want.clocks[i])
                            flag_mismatch($sformatf("clock%0d", i), got.clocks[i],
                                          want.clocks[i]);
                    if (want.before_flag) o_held++;
                    o_checked++;
                end
            end
            if (i_s_tvalid && i_s_tready)
                results_due.push_back(step_clock(t_kind'(i_s_tuser), i_s_tdata[3:0],
                                                 i_s_tdata[7:4], i_s_tdata[VEC_W+7:8]));
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_DIMENSION)
                    cfg_dim = i_cfg_data;
                else
                    cfg_own = i_cfg_data;
            end
        end
        o_pending = results_due.size();
    end

endmodule

/* tb/sv/vector_clock_unit_tb.sv */
// Testbench top for the vector clock unit: clock, reset, directed and random words,
// register settings, idle and stall patterns, verdict.
// Depends on vcu_pkg, vector_clock_unit and vector_clock_unit_monitor.
module vector_clock_unit_tb;
    import vcu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 60;
    localparam int HOLD_CYCLES = 200;

    typedef logic [LANES-1:0][CNT_W-1:0] t_lanes;

    logic                i_clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic                cfg_idx = REG_DIMENSION;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic                s_valid = 1'b0;
    logic [S_DATA_W-1:0] s_data = '0;
    logic [S_USER_W-1:0] s_user = '0;
    logic                m_ready = 1'b0;
    wire logic           s_ready;
    wire logic           m_valid;
    wire logic [M_DATA_W-1:0] m_data;

    int errors, pending, checked, held;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    bit hold_off_req = 1'b0;
    int words_sent = 0;
    int settings_used = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    vector_clock_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    vector_clock_unit_monitor u_monitor (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_valid),
        .i_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .i_s_tuser  (s_user),
        .i_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .i_m_tdata  (m_data),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_checked  (checked),
        .o_held     (held)
    );

    task automatic send(input t_kind kind, input logic [IDX_W-1:0] other_idx,
                        input logic [CFG_W-1:0] other_dim, input t_lanes given);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= kind;
        s_data  <= {given, other_dim, other_idx};
        do @(posedge i_clk); while (!s_ready);
        words_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] dim, input logic [CFG_W-1:0] own);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_DIMENSION;
        cfg_data <= dim;
        @(posedge i_clk);
        cfg_idx  <= REG_OWN_INDEX;
        cfg_data <= own;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        settings_used++;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        wait (rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                for (int n = 1; n < HOLD_CYCLES; n++) @(posedge i_clk);
            end else begin
                m_ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        t_lanes ones, zeros, most, given;
        logic [CFG_W-1:0] dim, own, other_dim;
        logic [IDX_W-1:0] other_idx;
        int sel;
        int src_pct[4];
        int sink_pct[4];

        src_pct  = '{0, 80, 0, 23};
        sink_pct = '{0, 0, 80, 23};
        ones  = '1;
        zeros = '0;
        most  = ones;
        most[0] = '0;
        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration: dimension 8, own index 1
        send(KIND_LOCAL, 4'hF, 4'hF, ones);
        send(KIND_RECV, 4'd1, 4'd8, zeros);
        send(KIND_RECV, 4'd2, 4'd7, ones);
        send(KIND_RECV, 4'd8, 4'd8, ones);
        send(KIND_STORED_BEFORE, 4'd0, 4'd8, ones);
        send(KIND_GIVEN_BEFORE, 4'd0, 4'd8, ones);
        send(KIND_STORED_BEFORE, 4'd0, 4'd8, most);
        send(KIND_GIVEN_BEFORE, 4'd0, 4'd8, most);
        send(KIND_RECV, 4'd3, 4'd8, zeros);
        send(KIND_GIVEN_BEFORE, 4'd0, 4'd0, zeros);
        send(KIND_STORED_BEFORE, 4'd0, 4'hF, ones);
        send(KIND_GIVEN_BEFORE, 4'd0, 4'd8, zeros);
        drain();

        // bad settings: zero, oversize dimension, own index out of range
        set_config(4'd0, 4'd1);
        send(KIND_LOCAL, 4'd2, 4'd0, zeros);
        send(KIND_RECV, 4'd2, 4'd0, ones);
        send(KIND_STORED_BEFORE, 4'd2, 4'd0, ones);
        send(KIND_GIVEN_BEFORE, 4'd2, 4'd0, zeros);
        drain();
        set_config(4'd9, 4'd1);
        send(KIND_LOCAL, 4'd2, 4'd9, zeros);
        drain();
        set_config(4'hF, 4'd1);
        send(KIND_RECV, 4'd2, 4'hF, ones);
        drain();
        set_config(4'd3, 4'd4);
        send(KIND_RECV, 4'd1, 4'd3, ones);
        drain();
        set_config(4'd8, 4'd0);
        send(KIND_LOCAL, 4'd1, 4'd8, zeros);
        drain();

        // smallest and largest valid settings
        set_config(4'd1, 4'd1);
        send(KIND_LOCAL, 4'd0, 4'd0, zeros);
        send(KIND_RECV, 4'd2, 4'd1, {{7{32'h0}}, 32'hFFFF_FFF0});
        send(KIND_RECV, 4'd1, 4'd1, ones);
        send(KIND_STORED_BEFORE, 4'd0, 4'd1, ones);
        drain();
        set_config(4'd8, 4'd8);
        send(KIND_LOCAL, 4'd0, 4'd0, zeros);
        send(KIND_RECV, 4'hF, 4'd8, {8{32'h0000_1234}});
        drain();

        for (int p = 0; p < PHASES; p++) begin
            if (p == 0) begin
                dim = 4'd8;
                own = 4'd8;
            end else if (p == 1) begin
                dim = 4'd1;
                own = 4'd1;
            end else if (p == PHASES - 1) begin
                dim = 4'($urandom_range(15));
                own = 4'($urandom_range(15));
            end else begin
                dim = 4'($urandom_range(8, 1));
                own = 4'($urandom_range(dim, 1));
            end
            set_config(dim, own);
            src_idle_pct   = src_pct[p % 4];
            sink_stall_pct = sink_pct[p % 4];
            if (p == 0) hold_off_req = 1'b1;
            for (int w = 0; w < PHASE_WORDS; w++) begin
                other_dim = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : dim;
                if ($urandom_range(9) == 0 || dim == 0)
                    other_idx = 4'($urandom_range(15));
                else
                    other_idx = 4'($urandom_range(dim, 1));
                sel = $urandom_range(9);
                for (int l = 0; l < LANES; l++) begin
                    if (sel < 4)
                        given[l] = $urandom_range(64);
                    else if (sel < 6)
                        given[l] = 32'hFFFF_FFFF - $urandom_range(3);
                    else if (sel < 8)
                        given[l] = $urandom;
                    else
                        given[l] = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
                end
                send(t_kind'($urandom_range(3)), other_idx, other_dim, given);
            end
            drain();
        end

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (8) @(posedge i_clk);
        $display("Sent %0d words under %0d register settings, all four kinds and idle mixes.",
                 words_sent, settings_used);
        $display("Checked %0d results; %0d compares found happens-before.", checked, held);
        if (errors == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
